/* rtl/core/i2c_master_byte_engine_macros.svh */
// Assertion macros for the I2C master byte engine.
// Included by the top level; relies on nothing else.
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CMB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CMB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/i2cmb_pkg.sv */
// Shared types and constants of the I2C master byte engine.
// No dependencies; every other file of the block but the macros header uses it.
`default_nettype none

package i2cmb_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [7:0] ACK_TIMEOUT_MIN   = 8'd1;

  // Register indexes (word address bits above the byte offset).
  localparam logic REG_ACK_TIMEOUT = 1'b0;

  // Command codes carried in the action field.
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_START   = 3'd2;
  localparam logic [2:0] ACT_STOP    = 3'd3;
  localparam logic [2:0] ACT_WRITE   = 3'd4;
  localparam logic [2:0] ACT_READ    = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_RELEASE = 6'b000010,
    ST_START   = 6'b000100,
    ST_STOP    = 6'b001000,
    ST_WRITE   = 6'b010000,
    ST_READ    = 6'b100000
  } cmd_state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       more_to_read;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       acked;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/i2cmb_in_if.sv */
// Valid/ready channel carrying one tick word into the engine.
// Depends on i2cmb_pkg for the payload type.
`default_nettype none

interface i2cmb_in_if;
  logic                valid;
  logic                ready;
  i2cmb_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/core/i2cmb_out_if.sv */
// Valid/ready channel carrying one result word out of the engine.
// Depends on i2cmb_pkg for the payload type.
`default_nettype none

interface i2cmb_out_if;
  logic                 valid;
  logic                 ready;
  i2cmb_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/core/i2c_master_byte_engine.sv */
// A result word is presented in the cycle after its tick word is accepted.
// Throughput: one tick word per cycle; the sequencer state steps once per accepted word.
// A word is taken whenever the output register is empty or being drained that cycle.
// Reset (rst_n low, synchronous) idles the sequencer, releases SCL and SDA, clears the
// read byte and acknowledge flag, sets ack_timeout to 250 and empties the output register.
// Depends on i2cmb_pkg, i2cmb_in_if, i2cmb_out_if, i2cmb_seq and the macros header.
`default_nettype none

`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  i2cmb_in_if.sink                               in_if,
  i2cmb_out_if.source                            out_if,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [i2cmb_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [i2cmb_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [i2cmb_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                   cfg_pready
);
  import i2cmb_pkg::*;

  logic [7:0] ack_timeout_r, ack_timeout_nxt;
  logic       cfg_wr;
  logic       cfg_hit;
  logic       step_en;
  out_item_t  res;
  out_item_t  out_r;
  logic       out_valid_r;

  // Configuration port. The register sits at word index 0; bit 2 of the byte
  // address selects the word, so any other word reads as zero and ignores writes.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1] == REG_ACK_TIMEOUT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;

  // A timeout of zero would end the poll before it started, so it is held at one.
  always_comb begin
    ack_timeout_nxt = ack_timeout_r;
    if (cfg_wr) begin
      ack_timeout_nxt = (cfg_pwdata[7:0] == 8'd0) ? ACK_TIMEOUT_MIN : cfg_pwdata[7:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_hit) cfg_prdata = {{(CFG_DATA_W-8){1'b0}}, ack_timeout_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RESET;
    end else begin
      ack_timeout_r <= ack_timeout_nxt;
    end
  end

  // Input handshake. The output register frees up in the same cycle it is read,
  // so a steady stream passes at one word per cycle with no bubble while the downstream side keeps reading.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign step_en     = in_if.valid && in_if.ready;

  // The sequencer computes this tick's line levels and status from its state and
  // the accepted word, and commits the new state on the same edge that loads the
  // result register below.
  i2cmb_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .item        (in_if.item),
    .ack_timeout (ack_timeout_r),
    .res         (res)
  );

  // Result register: holds a word until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) out_r <= res;
  end

  assign out_if.valid = out_valid_r;
  assign out_if.item  = out_r;

  // Checks on the block's own logic.
  `I2CMB_ASSERT_NOW(a_timeout_nonzero, clk, rst_n, 1'b1, ack_timeout_r != 8'd0, "ack_timeout register reached zero")
  `I2CMB_ASSERT_NEXT(a_zero_write_clamped, clk, rst_n, cfg_wr && (cfg_pwdata[7:0] == 8'd0), ack_timeout_r == ACK_TIMEOUT_MIN, "zero timeout write not held at one")
  `I2CMB_ASSERT_NEXT(a_step_loads_result, clk, rst_n, step_en, out_valid_r, "accepted word produced no result")
  `I2CMB_ASSERT_NOW(a_done_not_busy, clk, rst_n, out_valid_r && out_r.done_res, !out_r.busy_res, "finished command still reported busy")

endmodule

`default_nettype wire

/* rtl/core/i2cmb_seq.sv */
// Bus sequencer: command state, bit counters and line levels, one step per tick.
// Depends on i2cmb_pkg.
`default_nettype none

module i2cmb_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire i2cmb_pkg::in_item_t   item,
  input  wire logic [7:0]            ack_timeout,
  output i2cmb_pkg::out_item_t       res
);
  import i2cmb_pkg::*;

  cmd_state_t cmd_r, cmd_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic [7:0] last_read_r, last_read_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_r, ack_nxt;
  logic       send_ack_r, send_ack_nxt;
  logic       done;

  always_comb begin
    cmd_nxt       = cmd_r;
    phase_nxt     = phase_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    poll_nxt      = poll_r;
    last_read_nxt = last_read_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    ack_nxt       = ack_r;
    send_ack_nxt  = send_ack_r;
    done          = 1'b0;

    // A new command is only taken while idle; anything else is a plain tick.
    if (cmd_r == ST_IDLE) begin
      unique case (item.action)
        ACT_RELEASE: cmd_nxt = ST_RELEASE;
        ACT_START:   cmd_nxt = ST_START;
        ACT_STOP:    cmd_nxt = ST_STOP;
        ACT_WRITE: begin
          cmd_nxt   = ST_WRITE;
          shift_nxt = item.data_byte;
        end
        ACT_READ: begin
          cmd_nxt      = ST_READ;
          shift_nxt    = 8'd0;
          send_ack_nxt = item.more_to_read;
        end
        default: ;
      endcase
      phase_nxt   = 3'd0;
      bit_idx_nxt = 4'd0;
      poll_nxt    = 8'd0;
    end

    unique case (cmd_nxt)
      ST_IDLE: ;
      ST_RELEASE: begin
        if (phase_nxt == 3'd0) begin
          scl_nxt   = 1'b1;
          phase_nxt = 3'd1;
        end else begin
          sda_nxt = 1'b1;
          done    = 1'b1;
        end
      end
      ST_START: begin
        unique case (phase_nxt)
          3'd0:    sda_nxt = 1'b1;
          3'd1:    scl_nxt = 1'b1;
          3'd2:    sda_nxt = 1'b0;
          default: begin
            scl_nxt = 1'b0;
            done    = 1'b1;
          end
        endcase
        if (!done) phase_nxt = phase_nxt + 3'd1;
      end
      ST_STOP: begin
        unique case (phase_nxt)
          3'd0:    sda_nxt = 1'b0;
          3'd1:    scl_nxt = 1'b0;
          3'd2:    scl_nxt = 1'b1;
          default: begin
            sda_nxt = 1'b1;
            done    = 1'b1;
          end
        endcase
        if (!done) phase_nxt = phase_nxt + 3'd1;
      end
      ST_WRITE: begin
        unique case (phase_nxt)
          3'd0: begin
            sda_nxt   = shift_nxt[7];
            phase_nxt = 3'd1;
          end
          3'd1: begin
            scl_nxt   = 1'b1;
            phase_nxt = 3'd2;
          end
          3'd2: begin
            scl_nxt     = 1'b0;
            shift_nxt   = {shift_nxt[6:0], 1'b0};
            bit_idx_nxt = bit_idx_nxt + 4'd1;
            phase_nxt   = (bit_idx_nxt >= 4'd8) ? 3'd3 : 3'd0;
          end
          3'd3: begin
            sda_nxt   = 1'b1;
            phase_nxt = 3'd4;
          end
          3'd4: begin
            scl_nxt   = 1'b1;
            poll_nxt  = 8'd0;
            phase_nxt = 3'd5;
          end
          3'd5: begin
            if (!item.sda_in) begin
              ack_nxt   = 1'b1;
              phase_nxt = 3'd6;
            end else begin
              poll_nxt = poll_nxt + 8'd1;
              if (poll_nxt >= ack_timeout) begin
                ack_nxt   = 1'b0;
                phase_nxt = 3'd6;
              end
            end
          end
          default: begin
            scl_nxt = 1'b0;
            done    = 1'b1;
          end
        endcase
      end
      ST_READ: begin
        unique case (phase_nxt)
          3'd0: begin
            sda_nxt   = 1'b1;
            phase_nxt = 3'd1;
          end
          3'd1: begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_nxt[6:0], item.sda_in};
            phase_nxt = 3'd2;
          end
          3'd2: begin
            scl_nxt     = 1'b0;
            bit_idx_nxt = bit_idx_nxt + 4'd1;
            phase_nxt   = (bit_idx_nxt >= 4'd8) ? 3'd3 : 3'd1;
          end
          3'd3: begin
            sda_nxt   = ~send_ack_nxt;
            phase_nxt = 3'd4;
          end
          3'd4: begin
            scl_nxt   = 1'b1;
            phase_nxt = 3'd5;
          end
          default: begin
            scl_nxt       = 1'b0;
            last_read_nxt = shift_nxt;
            done          = 1'b1;
          end
        endcase
      end
      default: ;
    endcase

    if (done) begin
      cmd_nxt   = ST_IDLE;
      phase_nxt = 3'd0;
    end
  end

  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (cmd_nxt != ST_IDLE);
    res.done_res  = done;
    res.read_data = last_read_nxt;
    res.acked     = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= ST_IDLE;
      phase_r     <= 3'd0;
      bit_idx_r   <= 4'd0;
      shift_r     <= 8'd0;
      poll_r      <= 8'd0;
      last_read_r <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      send_ack_r  <= 1'b0;
    end else if (step_en) begin
      cmd_r       <= cmd_nxt;
      phase_r     <= phase_nxt;
      bit_idx_r   <= bit_idx_nxt;
      shift_r     <= shift_nxt;
      poll_r      <= poll_nxt;
      last_read_r <= last_read_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      ack_r       <= ack_nxt;
      send_ack_r  <= send_ack_nxt;
    end
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking bench for the I2C master byte engine: random bus command streams,
// a cycle-level predictor of SCL/SDA sequencing and APB writes of the acknowledge timeout.
// Depends on i2cmb_pkg, i2cmb_in_if, i2cmb_out_if and the engine RTL.
`timescale 1ns / 100ps

module tb;
  import i2cmb_pkg::*;

  // Action codes the engine does not decode; they must behave as plain ticks.
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  // Write sequence step at which SDA is polled for the slave's acknowledge.
  localparam logic [3:0] WR_ACK_POLL = 4'd5;

  localparam int PHASE_WORDS = 170;
  localparam int NUM_PHASES  = 5;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  // Everything the engine remembers between ticks, plus the last read byte.
  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] seq_step;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [7:0] polls;
    logic       scl;
    logic       sda;
    logic       acked;
    logic       ack_next;
    logic [7:0] last_byte;
  } bus_state_t;

  logic clk = 1'b0;
  logic rst_n;

  i2cmb_in_if  in_ch ();
  i2cmb_out_if out_ch ();

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Tick words waiting to be offered, and result words still owed by the engine.
  in_item_t  tick_words_q [$];
  out_item_t bus_results_q [$];

  // Two copies of the engine state: one follows the words the engine has taken,
  // the other runs ahead while the stimulus is built, so that commands can be
  // timed for the idle state and acknowledges placed inside the poll window.
  bus_state_t seen_state;
  bus_state_t plan_state;

  logic [7:0] ack_limit;
  int         ack_after;
  int         src_idle_pct;
  int         snk_stall_pct;
  logic       hold_off;
  logic       word_taken;
  int         phase_no;

  int fault_count;
  int words_sent;
  int words_checked;
  int acked_writes;
  int unacked_writes;
  int reads_done;
  int settings_used;

  i2c_master_byte_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // State straight out of reset: both lines released, nothing running.
  function automatic bus_state_t engine_reset();
    bus_state_t s;
    s = '0;
    s.cmd = ACT_TICK;
    s.scl = 1'b1;
    s.sda = 1'b1;
    return s;
  endfunction

  // Advances the engine by one tick and returns the levels it drives afterwards.
  // A command is taken only while idle; anything offered during a running command
  // is dropped, and the spare action codes never start anything.
  function automatic out_item_t engine_tick(inout bus_state_t s, input in_item_t w,
                                            input logic [7:0] limit);
    out_item_t r;
    logic      fin;
    fin = 1'b0;
    if (s.cmd == ACT_TICK && w.action >= ACT_RELEASE && w.action <= ACT_READ) begin
      s.cmd      = w.action;
      s.seq_step = '0;
      s.bit_cnt  = '0;
      s.polls    = '0;
      if (w.action == ACT_WRITE) s.shreg = w.data_byte;
      if (w.action == ACT_READ) begin
        s.shreg    = '0;
        s.ack_next = w.more_to_read;
      end
    end
    case (s.cmd)
      ACT_RELEASE: begin
        if (s.seq_step == 4'd0) begin
          s.scl      = 1'b1;
          s.seq_step = 4'd1;
        end else begin
          s.sda = 1'b1;
          fin   = 1'b1;
        end
      end
      ACT_START: begin
        // SDA high, SCL high, SDA falls while SCL is high, then SCL low.
        case (s.seq_step)
          4'd0: s.sda = 1'b1;
          4'd1: s.scl = 1'b1;
          4'd2: s.sda = 1'b0;
          default: begin
            s.scl = 1'b0;
            fin   = 1'b1;
          end
        endcase
        if (!fin) s.seq_step++;
      end
      ACT_STOP: begin
        // SDA low, SCL low, SCL high, then SDA rises while SCL is high.
        case (s.seq_step)
          4'd0: s.sda = 1'b0;
          4'd1: s.scl = 1'b0;
          4'd2: s.scl = 1'b1;
          default: begin
            s.sda = 1'b1;
            fin   = 1'b1;
          end
        endcase
        if (!fin) s.seq_step++;
      end
      ACT_WRITE: begin
        case (s.seq_step)
          4'd0: begin
            s.sda      = s.shreg[7];
            s.seq_step = 4'd1;
          end
          4'd1: begin
            s.scl      = 1'b1;
            s.seq_step = 4'd2;
          end
          4'd2: begin
            s.scl      = 1'b0;
            s.shreg    = {s.shreg[6:0], 1'b0};
            s.bit_cnt++;
            s.seq_step = (s.bit_cnt >= 4'd8) ? 4'd3 : 4'd0;
          end
          4'd3: begin
            s.sda      = 1'b1;
            s.seq_step = 4'd4;
          end
          4'd4: begin
            s.scl      = 1'b1;
            s.polls    = '0;
            s.seq_step = WR_ACK_POLL;
          end
          WR_ACK_POLL: begin
            // Any low SDA inside the window counts, however late it comes.
            if (!w.sda_in) begin
              s.acked    = 1'b1;
              s.seq_step = 4'd6;
            end else begin
              s.polls++;
              if (s.polls >= limit) begin
                s.acked    = 1'b0;
                s.seq_step = 4'd6;
              end
            end
          end
          default: begin
            s.scl = 1'b0;
            fin   = 1'b1;
          end
        endcase
      end
      ACT_READ: begin
        case (s.seq_step)
          4'd0: begin
            s.sda      = 1'b1;
            s.seq_step = 4'd1;
          end
          4'd1: begin
            s.scl      = 1'b1;
            s.shreg    = {s.shreg[6:0], w.sda_in};
            s.seq_step = 4'd2;
          end
          4'd2: begin
            s.scl      = 1'b0;
            s.bit_cnt++;
            s.seq_step = (s.bit_cnt >= 4'd8) ? 4'd3 : 4'd1;
          end
          4'd3: begin
            s.sda      = !s.ack_next;
            s.seq_step = 4'd4;
          end
          4'd4: begin
            s.scl      = 1'b1;
            s.seq_step = 4'd5;
          end
          default: begin
            s.scl       = 1'b0;
            s.last_byte = s.shreg;
            fin         = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
    if (fin) begin
      s.cmd      = ACT_TICK;
      s.seq_step = '0;
    end
    r.scl_out   = s.scl;
    r.sda_out   = s.sda;
    r.busy_res  = (s.cmd != ACT_TICK);
    r.done_res  = fin;
    r.read_data = s.last_byte;
    r.acked     = s.acked;
    return r;
  endfunction

  // SDA as the slave would drive it on the next tick: during the acknowledge poll
  // it holds SDA high until ack_after polls have passed, elsewhere it is random.
  function automatic logic bus_sda();
    if (plan_state.cmd == ACT_WRITE && plan_state.seq_step == WR_ACK_POLL)
      return (int'(plan_state.polls) >= ack_after) ? 1'b0 : 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic queue_word(input logic [2:0] action, input logic [7:0] data_byte,
                            input logic more, input logic sda);
    in_item_t w;
    w.action       = action;
    w.data_byte    = data_byte;
    w.more_to_read = more;
    w.sda_in       = sda;
    void'(engine_tick(plan_state, w, ack_limit));
    tick_words_q.push_back(w);
  endtask

  // Plain ticks until the planned command has run to completion.
  task automatic finish_command();
    while (plan_state.cmd != ACT_TICK)
      queue_word(ACT_TICK, 8'($urandom), 1'($urandom_range(0, 1)), bus_sda());
  endtask

  // Waits until every queued word has been taken and its result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (tick_words_q.size() != 0 || in_ch.valid || bus_results_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // APB write of the acknowledge timeout, setup phase then access phase; a zero behaves as one.
  task automatic write_timeout(input logic [7:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_ACK_TIMEOUT, 2'b00};
    cfg_pwdata  <= {{(CFG_DATA_W-8){1'b0}}, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    ack_limit = (value == 8'd0) ? ACK_TIMEOUT_MIN : value;
    settings_used++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  // Sender: a word stays on the channel until it is taken; a fresh one may be held
  // back at random to leave gaps between ticks.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || word_taken) begin
      if (tick_words_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_ch.item  <= tick_words_q.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off that backs the engine up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Monitor: each result word is checked against the oldest prediction, and each
  // tick word taken by the engine steps the predictor once.
  always @(posedge clk) begin : monitor
    out_item_t  want;
    out_item_t  got;
    logic [2:0] cmd_was;
    if (!rst_n) begin
      seen_state = engine_reset();
      word_taken = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.item;
        words_checked++;
        if (bus_results_q.size() == 0) begin
          $error("result word arrived with no tick word outstanding");
          fault_count++;
        end else begin
          want = bus_results_q.pop_front();
          check_field("scl_out", want.scl_out, got.scl_out);
          check_field("sda_out", want.sda_out, got.sda_out);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("read_data", want.read_data, got.read_data);
          check_field("acked", want.acked, got.acked);
        end
      end
      word_taken = in_ch.valid && in_ch.ready;
      if (word_taken) begin
        cmd_was = seen_state.cmd;
        want    = engine_tick(seen_state, in_ch.item, ack_limit);
        bus_results_q.push_back(want);
        words_sent++;
        // No command finishes on the tick it starts, so cmd_was names the one ending.
        if (want.done_res && cmd_was == ACT_WRITE) begin
          if (want.acked) acked_writes++;
          else unacked_writes++;
        end
        if (want.done_res && cmd_was == ACT_READ) reads_done++;
      end
    end
  end

  // Back-pressure: early in the first random phase the receiver refuses results for
  // a long stretch while the sender keeps offering, so the output register fills
  // and the engine has to stall its input.
  initial begin
    hold_off = 1'b0;
    wait (phase_no == 1);
    repeat (30) @(posedge clk);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (80) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d result words still owed", bus_results_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] timeout_plan [NUM_PHASES];
    idle_mode_t idle_plan [NUM_PHASES];
    int         pick;
    logic [2:0] action;
    logic [7:0] data_byte;

    timeout_plan = '{8'd255, 8'd1, 8'd0, 8'd37, 8'd250};
    idle_plan    = '{IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH, IDLE_BOTH};

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.item    = '0;
    out_ch.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    fault_count   = 0;
    words_sent    = 0;
    words_checked = 0;
    acked_writes  = 0;
    unacked_writes = 0;
    reads_done    = 0;
    settings_used = 0;
    phase_no      = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    ack_limit     = ACK_TIMEOUT_RESET;
    ack_after     = 0;
    plan_state    = engine_reset();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset timeout: plain and spare ticks, a release,
    // a start with a read offered while it runs (must be dropped), a write of all
    // ones whose acknowledge only comes on the third poll, a read that ends with
    // NACK, and a stop.
    queue_word(ACT_TICK, 8'h00, 1'b0, 1'b0);
    queue_word(ACT_SPARE_6, 8'hFF, 1'b1, 1'b1);
    queue_word(ACT_SPARE_7, 8'h5A, 1'b0, 1'b1);
    queue_word(ACT_RELEASE, 8'h00, 1'b0, 1'b1);
    finish_command();
    queue_word(ACT_START, 8'h00, 1'b0, 1'b1);
    queue_word(ACT_READ, 8'hFF, 1'b1, 1'b0);
    finish_command();
    ack_after = 2;
    queue_word(ACT_WRITE, 8'hFF, 1'b0, 1'b1);
    finish_command();
    queue_word(ACT_READ, 8'h00, 1'b0, 1'b1);
    finish_command();
    queue_word(ACT_STOP, 8'h00, 1'b0, 1'b0);
    finish_command();

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_timeout(timeout_plan[p]);
      case (idle_plan[p])
        IDLE_SRC: begin
          src_idle_pct  = 61;
          snk_stall_pct = 0;
        end
        IDLE_SNK: begin
          src_idle_pct  = 0;
          snk_stall_pct = 61;
        end
        IDLE_BOTH: begin
          src_idle_pct  = 33;
          snk_stall_pct = 33;
        end
        default: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
      endcase
      phase_no = p + 1;

      // Mostly well-formed commands issued while idle, followed by ticks that
      // carry a plausible slave response; one word in ten is pure noise.
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_word(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        end else if (plan_state.cmd == ACT_TICK) begin
          // Long timeouts make a missing acknowledge expensive, so it is rarer there.
          if ($urandom_range(0, (ack_limit > 8'd64) ? 15 : 2) == 0)
            ack_after = int'(ack_limit);
          else
            ack_after = $urandom_range(0, (ack_limit > 8'd12) ? 12 : int'(ack_limit) - 1);
          pick = $urandom_range(0, 99);
          if (pick < 35) action = ACT_WRITE;
          else if (pick < 65) action = ACT_READ;
          else if (pick < 77) action = ACT_START;
          else if (pick < 89) action = ACT_STOP;
          else if (pick < 95) action = ACT_RELEASE;
          else action = ACT_TICK;
          case ($urandom_range(0, 5))
            0: data_byte = 8'h00;
            1: data_byte = 8'hFF;
            default: data_byte = 8'($urandom);
          endcase
          queue_word(action, data_byte, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          action = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) : ACT_TICK;
          queue_word(action, 8'($urandom), 1'($urandom_range(0, 1)), bus_sda());
        end
      end
      finish_command();
    end

    wait_drained();
    repeat (4) @(posedge clk);

    $display("Checked %0d result words from %0d tick words over %0d timeout settings.",
             words_checked, words_sent, settings_used + 1);
    $display("Byte writes acknowledged %0d, left unacknowledged %0d; byte reads %0d.",
             acked_writes, unacked_writes, reads_done);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found", fault_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
